### sv/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared types and constants for the bus bit transceiver with backoff.
// ----------------------------------------------------------------------------
`default_nettype none

package bbt_pkg;

  localparam int PKT_DEPTH_DEF = 128;

  localparam logic [7:0] BACKOFF_LIMIT_RST = 8'd42;
  localparam logic [7:0] CARRIER_TICKS_RST = 8'd20;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;
  localparam logic [1:0] REQ_SEND = 2'd3;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_RX      = 3'd1;
  localparam logic [2:0] MODE_TX      = 3'd2;
  localparam logic [2:0] MODE_BREAK   = 3'd3;
  localparam logic [2:0] MODE_BACKOFF = 3'd4;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_STARTED   = 3'd1;
  localparam logic [2:0] ST_CARRIER   = 3'd2;
  localparam logic [2:0] ST_PRIO      = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;
  localparam logic [2:0] ST_COLLISION = 3'd6;

  localparam logic [0:0] REG_BACKOFF_LIMIT = 1'b0;
  localparam logic [0:0] REG_CARRIER_TICKS = 1'b1;

  localparam logic [7:0] OPC_LEN_MASK = 8'h60;
  localparam logic [7:0] XOR_SEED     = 8'hFF;
  localparam logic [7:0] STOP_TICK    = 8'd10;
  localparam logic [3:0] BREAK_LAST   = 4'd15;

  typedef struct packed {
    logic [7:0] backoff_limit;
    logic [7:0] carrier_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       rx_level;
    logic [7:0] tx_byte;
    logic [6:0] byte_index;
    logic [7:0] prio_delay;
  } step_in_t;

  typedef struct packed {
    logic       tx_level;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       frame_error;
    logic [2:0] send_status;
    logic [2:0] link_state;
  } step_out_t;

endpackage

`default_nettype wire

### sv/bbt_in_if.sv
// ----------------------------------------------------------------------------
// bbt_in_if
// Input item channel: request type and its payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       rx_level;
  logic [7:0] tx_byte;
  logic [6:0] byte_index;
  logic [7:0] prio_delay;

  modport source (
    output valid, req_type, rx_level, tx_byte, byte_index, prio_delay,
    input  ready
  );
  modport sink (
    input  valid, req_type, rx_level, tx_byte, byte_index, prio_delay,
    output ready
  );
endinterface

`default_nettype wire

### sv/bbt_out_if.sv
// ----------------------------------------------------------------------------
// bbt_out_if
// Result item channel: line level, received byte and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbt_out_if;
  logic       valid;
  logic       ready;
  logic       tx_level;
  logic [7:0] rx_data;
  logic       rx_valid;
  logic       frame_error;
  logic [2:0] send_status;
  logic [2:0] link_state;

  modport source (
    output valid, tx_level, rx_data, rx_valid, frame_error, send_status, link_state,
    input  ready
  );
  modport sink (
    input  valid, tx_level, rx_data, rx_valid, frame_error, send_status, link_state,
    output ready
  );
endinterface

`default_nettype wire

### sv/bbt_ram.sv
// ----------------------------------------------------------------------------
// bbt_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module bbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/bbt_cfg.sv
// ----------------------------------------------------------------------------
// bbt_cfg
// APB register file: backoff limit and carrier tick threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module bbt_cfg import bbt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [7:0] backoff_limit_r, backoff_limit_nxt;
  logic [7:0] carrier_ticks_r, carrier_ticks_nxt;
  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    backoff_limit_nxt = backoff_limit_r;
    carrier_ticks_nxt = carrier_ticks_r;
    if (wr_en) begin
      case (reg_idx)
        REG_BACKOFF_LIMIT: backoff_limit_nxt = pwdata[7:0];
        REG_CARRIER_TICKS: carrier_ticks_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BACKOFF_LIMIT: prdata = {24'd0, backoff_limit_r};
      REG_CARRIER_TICKS: prdata = {24'd0, carrier_ticks_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_limit_r <= BACKOFF_LIMIT_RST;
      carrier_ticks_r <= CARRIER_TICKS_RST;
    end else begin
      backoff_limit_r <= backoff_limit_nxt;
      carrier_ticks_r <= carrier_ticks_nxt;
    end
  end

  assign cfg.backoff_limit = backoff_limit_r;
  assign cfg.carrier_ticks = carrier_ticks_r;

endmodule

`default_nettype wire

### sv/bbt_core.sv
// ----------------------------------------------------------------------------
// bbt_core
// Link state and next-state logic for one item; packet store with
// look-ahead read of the next byte to send.
// ----------------------------------------------------------------------------
`default_nettype none

module bbt_core import bbt_pkg::*; #(
  parameter int PACKET_DEPTH = PKT_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  step_in_t       din,
  input  cfg_t           cfg,
  output step_out_t      dout
);

  localparam int AW = $clog2(PACKET_DEPTH);
  localparam int LW = $clog2(PACKET_DEPTH + 1);
  localparam logic [7:0] DEPTH8 = 8'(PACKET_DEPTH);

  logic [2:0]    mode_r, mode_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic [7:0]    rx_shift_r, rx_shift_nxt;
  logic [AW-1:0] send_index_r, send_index_nxt;
  logic [LW-1:0] send_length_r, send_length_nxt;
  logic [7:0]    tx_shift_r, tx_shift_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          line_r, line_nxt;
  logic [3:0]    break_r, break_nxt;

  // copies of bytes 0 and 1 for the length decode at send start
  logic [7:0]    b0_r, b1_r;

  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_q;
  logic          byp_hit_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    pf_byte;

  logic [7:0]    tc_inc;
  logic [7:0]    prio_clip;
  logic [LW:0]   idx_p1, idx_p2, len_ext;
  logic [7:0]    len_raw, len_sat;
  logic [LW-1:0] len_start;
  logic [3:0]    break_inc;
  logic [2:0]    mode_eff;
  logic [2:0]    status;
  logic          rvalid, ferr;
  logic [7:0]    rdata;
  logic [AW-1:0] si_next;

  assign pf_byte   = byp_hit_r ? byp_data_r : ram_q;
  assign tc_inc    = (tick_r == 8'hFF) ? tick_r : tick_r + 8'd1;
  assign prio_clip = (din.prio_delay > cfg.backoff_limit) ? cfg.backoff_limit
                                                          : din.prio_delay;
  assign idx_p1    = (LW+1)'(send_index_r) + (LW+1)'(1);
  assign idx_p2    = (LW+1)'(send_index_r) + (LW+1)'(2);
  assign len_ext   = {1'b0, send_length_r};
  assign break_inc = break_r + 4'd1;

  always_comb begin
    if ((b0_r & OPC_LEN_MASK) == OPC_LEN_MASK) begin
      len_raw = b1_r;
    end else begin
      len_raw = {5'd0, b0_r[6:5], 1'b0} + 8'd2;
    end
    if (len_raw > DEPTH8) begin
      len_sat = DEPTH8;
    end else if (len_raw == 8'd0) begin
      len_sat = 8'd1;
    end else begin
      len_sat = len_raw;
    end
    len_start = LW'(len_sat);
  end

  assign wr_en = acc && (din.req_type == REQ_LOAD) &&
                 ({1'b0, din.byte_index} < DEPTH8);

  always_comb begin
    mode_nxt        = mode_r;
    tick_nxt        = tick_r;
    rx_shift_nxt    = rx_shift_r;
    send_index_nxt  = send_index_r;
    send_length_nxt = send_length_r;
    tx_shift_nxt    = tx_shift_r;
    xor_nxt         = xor_r;
    line_nxt        = line_r;
    break_nxt       = break_r;
    mode_eff        = mode_r;
    status          = ST_NONE;
    rvalid          = 1'b0;
    ferr            = 1'b0;
    rdata           = 8'd0;
    case (din.req_type)
      REQ_TICK: begin
        tick_nxt = tc_inc;
        case (mode_r)
          MODE_RX: begin
            if (tc_inc < STOP_TICK) begin
              rx_shift_nxt = {din.rx_level, rx_shift_r[7:1]};
            end else begin
              if (din.rx_level) begin
                rvalid = 1'b1;
                rdata  = rx_shift_r;
              end else begin
                ferr = 1'b1;
              end
              rx_shift_nxt = 8'd0;
              tick_nxt     = 8'd0;
              mode_nxt     = MODE_BACKOFF;
            end
          end
          MODE_TX: begin
            if (din.rx_level != line_r) begin
              line_nxt  = 1'b0;
              break_nxt = 4'd0;
              tick_nxt  = 8'd0;
              mode_nxt  = MODE_BREAK;
              status    = ST_COLLISION;
            end else if (tc_inc <= 8'd1) begin
              line_nxt = 1'b0;
            end else if (tc_inc < STOP_TICK) begin
              line_nxt     = tx_shift_r[0];
              tx_shift_nxt = {1'b0, tx_shift_r[7:1]};
            end else if (tc_inc == STOP_TICK) begin
              line_nxt = 1'b1;
            end else if (idx_p1 < len_ext) begin
              send_index_nxt = send_index_r + AW'(1);
              tick_nxt       = 8'd0;
              if (idx_p2 >= len_ext) begin
                tx_shift_nxt = xor_r;
              end else begin
                tx_shift_nxt = pf_byte;
                xor_nxt      = xor_r ^ pf_byte;
              end
            end else begin
              tick_nxt = 8'd0;
              mode_nxt = MODE_BACKOFF;
              status   = ST_DONE;
            end
          end
          MODE_BREAK: begin
            break_nxt = break_inc;
            if (break_inc == BREAK_LAST) begin
              line_nxt  = 1'b1;
              break_nxt = 4'd0;
              tick_nxt  = 8'd0;
              mode_nxt  = MODE_BACKOFF;
            end
          end
          MODE_BACKOFF: begin
            if (tc_inc >= cfg.backoff_limit) begin
              mode_nxt = MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      REQ_EDGE: begin
        if (mode_r == MODE_IDLE || mode_r == MODE_BACKOFF) begin
          mode_nxt     = MODE_RX;
          tick_nxt     = 8'd0;
          rx_shift_nxt = 8'd0;
        end
      end
      REQ_LOAD: ;
      REQ_SEND: begin
        if (mode_r == MODE_BACKOFF) begin
          if (tick_r >= prio_clip) begin
            mode_eff = MODE_IDLE;
          end else if (tick_r < cfg.carrier_ticks) begin
            status = ST_CARRIER;
          end else begin
            status = ST_PRIO;
          end
        end
        mode_nxt = mode_eff;
        if (status == ST_NONE) begin
          if (mode_eff != MODE_IDLE) begin
            status = ST_BUSY;
          end else begin
            send_length_nxt = len_start;
            send_index_nxt  = '0;
            tick_nxt        = 8'd0;
            mode_nxt        = MODE_TX;
            status          = ST_STARTED;
            if (len_start == LW'(1)) begin
              tx_shift_nxt = XOR_SEED;
              xor_nxt      = XOR_SEED;
            end else begin
              tx_shift_nxt = b0_r;
              xor_nxt      = XOR_SEED ^ b0_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign dout.tx_level    = line_nxt;
  assign dout.rx_data     = rdata;
  assign dout.rx_valid    = rvalid;
  assign dout.frame_error = ferr;
  assign dout.send_status = status;
  assign dout.link_state  = mode_nxt;

  // look-ahead: always read the entry after the current send position
  assign si_next = acc ? send_index_nxt : send_index_r;
  assign rd_addr = si_next + AW'(1);

  bbt_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (din.byte_index[AW-1:0]),
    .wdata (din.tx_byte),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    byp_data_r <= din.tx_byte;
    if (wr_en && din.byte_index[AW-1:0] == AW'(0)) begin
      b0_r <= din.tx_byte;
    end
    if (wr_en && din.byte_index[AW-1:0] == AW'(1)) begin
      b1_r <= din.tx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r     <= 1'b0;
      mode_r        <= MODE_IDLE;
      tick_r        <= 8'd0;
      rx_shift_r    <= 8'd0;
      send_index_r  <= '0;
      send_length_r <= '0;
      tx_shift_r    <= 8'd0;
      xor_r         <= XOR_SEED;
      line_r        <= 1'b1;
      break_r       <= 4'd0;
    end else begin
      byp_hit_r <= wr_en && (din.byte_index[AW-1:0] == rd_addr);
      if (acc) begin
        mode_r        <= mode_nxt;
        tick_r        <= tick_nxt;
        rx_shift_r    <= rx_shift_nxt;
        send_index_r  <= send_index_nxt;
        send_length_r <= send_length_nxt;
        tx_shift_r    <= tx_shift_nxt;
        xor_r         <= xor_nxt;
        line_r        <= line_nxt;
        break_r       <= break_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### sv/bus_bit_transceiver_with_backoff.sv
// Output: the result item is registered and presented in the cycle after its input item is accepted.
// Throughput: one item per cycle; the input stalls only while a result is held
//   and the result side is not ready.
// Reset (rst_n, synchronous, active low): link idle, counters cleared, line
//   released, checksum seed 0xFF, registers to 42 and 20; packet store not cleared.
// ----------------------------------------------------------------------------
// bus_bit_transceiver_with_backoff
// Half-duplex serial bus transceiver with carrier backoff and collision break.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_bit_transceiver_with_backoff import bbt_pkg::*; #(
  parameter int PACKET_DEPTH = PKT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bbt_in_if.sink           in_ch,
  bbt_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  step_in_t  din;
  step_out_t dout;
  step_out_t res_r;
  logic      out_valid_r, out_valid_nxt;
  logic      acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;

  assign din.req_type   = in_ch.req_type;
  assign din.rx_level   = in_ch.rx_level;
  assign din.tx_byte    = in_ch.tx_byte;
  assign din.byte_index = in_ch.byte_index;
  assign din.prio_delay = in_ch.prio_delay;

  bbt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bbt_core #(
    .PACKET_DEPTH (PACKET_DEPTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .din   (din),
    .cfg   (cfg),
    .dout  (dout)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= dout;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_level    = res_r.tx_level;
  assign out_ch.rx_data     = res_r.rx_data;
  assign out_ch.rx_valid    = res_r.rx_valid;
  assign out_ch.frame_error = res_r.frame_error;
  assign out_ch.send_status = res_r.send_status;
  assign out_ch.link_state  = res_r.link_state;

endmodule

`default_nettype wire
